>>> rtl/core/lmts_pkg.sv
// Shared types, mode codes and timing constants for the LCD mode timing sequencer.
package lmts_pkg;

  // Mode codes as they appear on the result
  localparam logic [1:0] MODE_HBLK     = 2'd0;
  localparam logic [1:0] MODE_VBLK     = 2'd1;
  localparam logic [1:0] MODE_SEARCH   = 2'd2;
  localparam logic [1:0] MODE_TRANSFER = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HBLANK_EN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VBLANK_EN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_EN    = 2'd3;
  localparam int unsigned CFG_DATA_W = 8;

  // Field widths
  localparam int unsigned DOTS_W = 8;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned LINE_W = 8;

  // Dot thresholds of each mode
  localparam logic [CNT_W-1:0] SEARCH_DOTS   = 16'd79;
  localparam logic [CNT_W-1:0] TRANSFER_DOTS = 16'd172;
  localparam logic [CNT_W-1:0] HBLANK_DOTS   = 16'd205;
  localparam logic [CNT_W-1:0] LINE_DOTS     = 16'd456;
  localparam logic [CNT_W-1:0] VBLANK_DOTS   = 16'd4560;
  localparam int unsigned VBLANK_ROWS = 4560 / 456;

  // Default number of visible lines
  localparam int unsigned DEF_VISIBLE_LINES = 144;

  // Configuration register contents
  typedef struct packed {
    logic [LINE_W-1:0] line_compare;
    logic              hblank_en;
    logic              vblank_en;
    logic              search_en;
  } cfg_t;

  // One result of a step
  typedef struct packed {
    logic [1:0]        mode_now;
    logic [LINE_W-1:0] line_now;
    logic              coincidence;
    logic              vblank_request;
    logic              stat_request;
    logic              frame_done;
  } result_t;

endpackage

>>> rtl/core/lmts_cfg.sv
// Configuration register file of the LCD mode timing sequencer.
module lmts_cfg
  import lmts_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index and keep the used bits of the data.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LINE_COMPARE: cfg_d.line_compare = cfg_wdata_i[LINE_W-1:0];
        REG_HBLANK_EN:    cfg_d.hblank_en    = cfg_wdata_i[0];
        REG_VBLANK_EN:    cfg_d.vblank_en    = cfg_wdata_i[0];
        REG_SEARCH_EN:    cfg_d.search_en    = cfg_wdata_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/lmts_step.sv
// Mode, dot counter and line state with the single-step update logic.
module lmts_step
  import lmts_pkg::*;
#(
  parameter int unsigned VISIBLE_LINES = DEF_VISIBLE_LINES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  logic [DOTS_W-1:0] dots_i,
  input  cfg_t              cfg_i,
  output result_t           result_o
);

  localparam logic [LINE_W:0] VisLines = (LINE_W+1)'(VISIBLE_LINES);

  logic [1:0]        mode_q, mode_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LINE_W-1:0] line_q, line_d;

  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  cnt_sat;
  logic [LINE_W-1:0] line_inc;
  logic [3:0]        row;
  logic [LINE_W:0]   line_vb;
  logic              vb_pulse, stat_pulse, frame;

  // Saturating add of the elapsed dots.
  assign sum     = {1'b0, cnt_q} + (CNT_W+1)'(dots_i);
  assign cnt_sat = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  assign line_inc = line_q + LINE_W'(1);

  // Row within vertical blank: count of whole lines passed, by constant compares.
  always_comb begin
    row = '0;
    for (int k = 1; k < VBLANK_ROWS; k++) begin
      if (cnt_sat >= CNT_W'(k * 456)) begin
        row = 4'(k);
      end
    end
  end
  assign line_vb = (LINE_W+1)'(row) + VisLines;

  // One mode change at most per step.
  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_sat;
    line_d     = line_q;
    vb_pulse   = 1'b0;
    stat_pulse = 1'b0;
    frame      = 1'b0;
    case (mode_q)
      MODE_SEARCH: begin
        if (cnt_sat >= SEARCH_DOTS) begin
          cnt_d  = cnt_sat - SEARCH_DOTS;
          mode_d = MODE_TRANSFER;
        end
      end
      MODE_TRANSFER: begin
        if (cnt_sat >= TRANSFER_DOTS) begin
          cnt_d      = cnt_sat - TRANSFER_DOTS;
          mode_d     = MODE_HBLK;
          stat_pulse = cfg_i.hblank_en;
        end
      end
      MODE_HBLK: begin
        if (cnt_sat >= HBLANK_DOTS) begin
          cnt_d  = cnt_sat - HBLANK_DOTS;
          line_d = line_inc;
          if ({1'b0, line_inc} >= VisLines) begin
            mode_d     = MODE_VBLK;
            vb_pulse   = 1'b1;
            stat_pulse = cfg_i.vblank_en;
            frame      = 1'b1;
          end else begin
            mode_d     = MODE_SEARCH;
            stat_pulse = cfg_i.search_en;
          end
        end
      end
      default: begin
        if (cnt_sat < VBLANK_DOTS) begin
          line_d = line_vb[LINE_W-1:0];
        end else begin
          cnt_d      = cnt_sat - VBLANK_DOTS;
          line_d     = '0;
          mode_d     = MODE_SEARCH;
          stat_pulse = cfg_i.search_en;
        end
      end
    endcase
  end

  // State advances once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEARCH;
      cnt_q  <= '0;
      line_q <= '0;
    end else if (step_en_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      line_q <= line_d;
    end
  end

  // Result of this step.
  always_comb begin
    result_o.mode_now       = mode_d;
    result_o.line_now       = line_d;
    result_o.coincidence    = (line_d == cfg_i.line_compare);
    result_o.vblank_request = vb_pulse;
    result_o.stat_request   = stat_pulse;
    result_o.frame_done     = frame;
  end

endmodule

>>> rtl/core/lcd_mode_timing_sequencer_unit.sv
// A request taken into the input register is stepped into the result register.
// Throughput: one request per cycle; the input and result registers both move
// whenever the result register is empty or its request is being taken.
// The step itself is one saturating add, a few constant compares and a subtract.
// Reset (asynchronous, active low) empties both registers, puts the sequencer in
// object search with counter and line at zero, and clears all configuration.
module lcd_mode_timing_sequencer_unit
  import lmts_pkg::*;
#(
  parameter int unsigned VISIBLE_LINES = DEF_VISIBLE_LINES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DOTS_W-1:0]     elapsed_dots_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            mode_now_o,
  output logic [LINE_W-1:0]     line_now_o,
  output logic                  coincidence_o,
  output logic                  vblank_request_o,
  output logic                  stat_request_o,
  output logic                  frame_done_o
);

  cfg_t              cfg;
  result_t           step_res;
  result_t           res_q;
  logic              in_vld_q, out_vld_q;
  logic [DOTS_W-1:0] dots_q;
  logic              advance, step_en;

  lmts_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Pipeline moves when the result register is free or being drained.
  assign advance    = !out_vld_q || !out_stall_i;
  assign step_en    = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      dots_q <= elapsed_dots_i;
    end
  end

  lmts_step #(
    .VISIBLE_LINES (VISIBLE_LINES)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .dots_i    (dots_q),
    .cfg_i     (cfg),
    .result_o  (step_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign mode_now_o       = res_q.mode_now;
  assign line_now_o       = res_q.line_now;
  assign coincidence_o    = res_q.coincidence;
  assign vblank_request_o = res_q.vblank_request;
  assign stat_request_o   = res_q.stat_request;
  assign frame_done_o     = res_q.frame_done;

endmodule

>>> rtl/core/lmts_checker.sv
// Port-level assertions for the LCD mode timing sequencer and their binding.
module lmts_checker
  import lmts_pkg::*;
#(
  parameter int unsigned VISIBLE_LINES = DEF_VISIBLE_LINES
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        mode_now_o,
  input logic [LINE_W-1:0] line_now_o,
  input logic              vblank_request_o,
  input logic              frame_done_o
);

  localparam logic [LINE_W:0] VisLines = (LINE_W+1)'(VISIBLE_LINES);

  // A stalled result keeps its mode and line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_now_o) && $stable(line_now_o))
    else $error("stalled result changed");

  // A finished frame always comes with entry into vertical blank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> vblank_request_o)
    else $error("frame done without vblank request");

  // A vertical blank request reports the vertical blank mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vblank_request_o |-> mode_now_o == MODE_VBLK)
    else $error("vblank request outside vertical blank");

  // Outside vertical blank the line is a visible one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_now_o != MODE_VBLK |-> {1'b0, line_now_o} < VisLines)
    else $error("visible mode on a blank line");

endmodule

bind lcd_mode_timing_sequencer_unit lmts_checker #(
  .VISIBLE_LINES (VISIBLE_LINES)
) u_lmts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .mode_now_o       (mode_now_o),
  .line_now_o       (line_now_o),
  .vblank_request_o (vblank_request_o),
  .frame_done_o     (frame_done_o)
);

>>> tb/tb.sv
// Self-checking testbench for the LCD scanline mode timing sequencer.
`timescale 1ns / 100ps

module tb;
  import lmts_pkg::*;

  localparam int unsigned VISIBLE      = DEF_VISIBLE_LINES;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned TABLE_ROWS   = 20;

  // One row of the directed sequence; result is only used when pinned is set
  typedef struct packed {
    logic [DOTS_W-1:0] dots;
    logic              pinned;
    result_t           result;
  } dot_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [DOTS_W-1:0]     elapsed_dots_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [1:0]            mode_now_o;
  logic [LINE_W-1:0]     line_now_o;
  logic                  coincidence_o;
  logic                  vblank_request_o;
  logic                  stat_request_o;
  logic                  frame_done_o;

  // Side information that travels with the request being offered
  logic    req_pinned;
  result_t req_result;

  // Predicted sequencer state and its register copy
  logic [1:0]        pred_mode;
  logic [CNT_W-1:0]  pred_dots;
  logic [LINE_W-1:0] pred_line;
  cfg_t              mode_cfg;

  result_t scanline_results[$];
  result_t seen;
  result_t want;
  logic    active;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned idle_cycles;
  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned frames_seen;
  int unsigned stat_seen;
  int unsigned match_seen;
  int unsigned saturated_steps;
  int unsigned reg_writes;

  dot_row_t dot_table [TABLE_ROWS] = '{
    '{8'd0,   1'b1, '{MODE_SEARCH,   8'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'd78,  1'b1, '{MODE_SEARCH,   8'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'd1,   1'b1, '{MODE_TRANSFER, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'd171, 1'b1, '{MODE_TRANSFER, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'd1,   1'b1, '{MODE_HBLK,     8'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'd204, 1'b1, '{MODE_HBLK,     8'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'd1,   1'b1, '{MODE_SEARCH,   8'd1, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{8'd255, 1'b0, '0},
    '{8'd0,   1'b0, '0},
    '{8'd255, 1'b0, '0},
    '{8'd255, 1'b0, '0},
    '{8'd255, 1'b0, '0},
    '{8'd255, 1'b0, '0},
    '{8'd0,   1'b0, '0},
    '{8'd0,   1'b0, '0},
    '{8'd0,   1'b0, '0},
    '{8'd128, 1'b0, '0},
    '{8'd255, 1'b0, '0},
    '{8'd1,   1'b0, '0},
    '{8'd254, 1'b0, '0}
  };

  lcd_mode_timing_sequencer_unit #(
    .VISIBLE_LINES(VISIBLE)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .elapsed_dots_i  (elapsed_dots_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mode_now_o      (mode_now_o),
    .line_now_o      (line_now_o),
    .coincidence_o   (coincidence_o),
    .vblank_request_o(vblank_request_o),
    .stat_request_o  (stat_request_o),
    .frame_done_o    (frame_done_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The result side stalls at random with the current idle rate.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Advances the predicted sequencer by one step and returns the result it gives.
  function automatic result_t advance_scanline(input logic [DOTS_W-1:0] dots);
    logic [CNT_W:0] sum;
    logic [1:0]     next_mode;
    logic           frame;
    logic           entered;
    result_t        r;
    sum = (CNT_W+1)'(pred_dots) + (CNT_W+1)'(dots);
    if (sum[CNT_W]) begin
      pred_dots = '1;
      saturated_steps++;
    end else begin
      pred_dots = sum[CNT_W-1:0];
    end
    next_mode = pred_mode;
    frame = 1'b0;
    case (pred_mode)
      MODE_SEARCH: begin
        if (pred_dots >= SEARCH_DOTS) begin
          pred_dots = pred_dots - SEARCH_DOTS;
          next_mode = MODE_TRANSFER;
        end
      end
      MODE_TRANSFER: begin
        if (pred_dots >= TRANSFER_DOTS) begin
          pred_dots = pred_dots - TRANSFER_DOTS;
          next_mode = MODE_HBLK;
        end
      end
      MODE_HBLK: begin
        if (pred_dots >= HBLANK_DOTS) begin
          pred_dots = pred_dots - HBLANK_DOTS;
          pred_line = pred_line + 8'd1;
          if (pred_line >= VISIBLE) begin
            next_mode = MODE_VBLK;
            frame = 1'b1;
          end else begin
            next_mode = MODE_SEARCH;
          end
        end
      end
      default: begin
        // In vertical blank the line follows the counter until the blank ends.
        if (pred_dots < VBLANK_DOTS) begin
          pred_line = LINE_W'(pred_dots / LINE_DOTS + VISIBLE);
        end else begin
          pred_dots = pred_dots - VBLANK_DOTS;
          pred_line = '0;
          next_mode = MODE_SEARCH;
        end
      end
    endcase
    entered = (next_mode != pred_mode);
    r.vblank_request = entered && (next_mode == MODE_VBLK);
    r.stat_request = entered && ((next_mode == MODE_VBLK && mode_cfg.vblank_en) ||
                                 (next_mode == MODE_HBLK && mode_cfg.hblank_en) ||
                                 (next_mode == MODE_SEARCH && mode_cfg.search_en));
    pred_mode = next_mode;
    r.mode_now = pred_mode;
    r.line_now = pred_line;
    r.coincidence = (pred_line == mode_cfg.line_compare);
    r.frame_done = frame;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned got_val);
    if (exp_val != got_val) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
    end
  endtask

  // Takes requests into the prediction queue and checks results against it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      active = cfg_we_i;
      if (out_valid_o && !out_stall_i) begin
        active = 1'b1;
        seen = '{mode_now_o, line_now_o, coincidence_o, vblank_request_o,
                 stat_request_o, frame_done_o};
        if (scanline_results.size() == 0) begin
          error_count++;
          $display("%0t: result with no request outstanding, got %p", $time, seen);
        end else begin
          want = scanline_results.pop_front();
          results_seen++;
          frames_seen += want.frame_done;
          stat_seen += want.stat_request;
          match_seen += want.coincidence;
          check_field("mode_now", 32'(want.mode_now), 32'(seen.mode_now));
          check_field("line_now", 32'(want.line_now), 32'(seen.line_now));
          check_field("coincidence", 32'(want.coincidence), 32'(seen.coincidence));
          check_field("vblank_request", 32'(want.vblank_request),
                      32'(seen.vblank_request));
          check_field("stat_request", 32'(want.stat_request), 32'(seen.stat_request));
          check_field("frame_done", 32'(want.frame_done), 32'(seen.frame_done));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        active = 1'b1;
        want = advance_scanline(elapsed_dots_i);
        if (req_pinned) begin
          want = req_result;
        end
        scanline_results.push_back(want);
      end
      idle_cycles = active ? 0 : idle_cycles + 1;
    end
  end

  // Ends the run when no handshake has happened for too long.
  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  // Offers one request after a random gap and holds it until it is taken.
  task automatic send_request(input logic [DOTS_W-1:0] dots, input logic pinned,
                              input result_t result);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    elapsed_dots_i <= dots;
    req_pinned     <= pinned;
    req_result     <= result;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (scanline_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    reg_writes++;
  endtask

  // Enable registers only use bit 0, so the upper data bits are random.
  task automatic program_sequencer(input logic [LINE_W-1:0] line_cmp, input logic hb_en,
                                   input logic vb_en, input logic se_en);
    wait_drained();
    write_register(REG_LINE_COMPARE, line_cmp);
    write_register(REG_HBLANK_EN, {7'($urandom_range(0, 127)), hb_en});
    write_register(REG_VBLANK_EN, {7'($urandom_range(0, 127)), vb_en});
    write_register(REG_SEARCH_EN, {7'($urandom_range(0, 127)), se_en});
    cfg_we_i <= 1'b0;
    mode_cfg.line_compare = line_cmp;
    mode_cfg.hblank_en    = hb_en;
    mode_cfg.vblank_en    = vb_en;
    mode_cfg.search_en    = se_en;
  endtask

  // Mostly large steps so that frames complete, with small and extreme ones mixed in.
  function automatic logic [DOTS_W-1:0] pick_dots();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return DOTS_W'($urandom_range(150, 255));
    if (roll < 75) return DOTS_W'($urandom_range(0, 255));
    if (roll < 90) return DOTS_W'($urandom_range(0, 8));
    return roll[0] ? 8'hFF : 8'h00;
  endfunction

  task automatic run_traffic(input int unsigned count, input int unsigned send_pct,
                             input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 199) == 0) begin
        wait_drained();
      end
      send_request(pick_dots(), 1'b0, '0);
    end
  endtask

  // Main sequence: directed table, then random phases with different settings.
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    elapsed_dots_i = '0;
    req_pinned     = 1'b0;
    req_result     = '0;
    pred_mode      = MODE_SEARCH;
    pred_dots      = '0;
    pred_line      = '0;
    mode_cfg       = '0;
    send_idle_pct  = 12;
    recv_idle_pct  = 76;
    idle_cycles    = 0;
    error_count    = 0;
    requests_sent  = 0;
    results_seen   = 0;
    frames_seen    = 0;
    stat_seen      = 0;
    match_seen     = 0;
    saturated_steps = 0;
    reg_writes     = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Exact thresholds of each mode from reset, then a growing backlog.
    for (int unsigned r = 0; r < TABLE_ROWS; r++) begin
      send_request(dot_table[r].dots, dot_table[r].pinned, dot_table[r].result);
    end

    program_sequencer(8'd255, 1'b1, 1'b0, 1'b0);
    run_traffic(250, 12, 76);
    program_sequencer(8'd144, 1'b0, 1'b1, 1'b1);
    run_traffic(250, 76, 12);
    program_sequencer(LINE_W'($urandom_range(1, 153)), 1'b1, 1'b1, 1'b1);
    run_traffic(200, 0, 0);

    // Full-size steps pile up a backlog until the counter saturates, then drain.
    program_sequencer(8'd0, 1'b1, 1'b1, 1'b1);
    for (int unsigned i = 0; i < 850; i++) begin
      send_request(8'hFF, 1'b0, '0);
    end
    for (int unsigned i = 0; i < 40; i++) begin
      send_request(8'h00, 1'b0, '0);
    end
    wait_drained();

    $display("Summary: %0d dot steps, %0d results compared, %0d frames, %0d stat pulses",
             requests_sent, results_seen, frames_seen, stat_seen);
    $display("Summary: %0d line matches, %0d saturated steps, %0d register writes, %0d errors",
             match_seen, saturated_steps, reg_writes, error_count);
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
